// ----- rtl/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types, constants and the millisecond stamp function for the
// subtitle line classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  localparam int MAX_HOUR_DIGITS_DEF = 9;
  localparam int HOUR_ACC_W          = 30;
  localparam int STAMP_W             = 52;
  localparam int MIN_ACC_W           = 7;
  localparam int SEC_ACC_W           = 7;
  localparam int MILLI_ACC_W         = 10;
  localparam int DCNT_W              = 4;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [13:0] {
    PH_WS0  = 14'h0001,
    PH_H1   = 14'h0002,
    PH_M1   = 14'h0004,
    PH_S1   = 14'h0008,
    PH_F1   = 14'h0010,
    PH_WS1  = 14'h0020,
    PH_D1   = 14'h0040,
    PH_D2   = 14'h0080,
    PH_WS2  = 14'h0100,
    PH_H2   = 14'h0200,
    PH_M2   = 14'h0400,
    PH_S2   = 14'h0800,
    PH_F2   = 14'h1000,
    PH_DONE = 14'h2000
  } phase_t;

  function automatic logic [STAMP_W-1:0] stamp_ms(
    input logic [HOUR_ACC_W-1:0]  hour,
    input logic [MIN_ACC_W-1:0]   minute,
    input logic [SEC_ACC_W-1:0]   second,
    input logic [MILLI_ACC_W-1:0] milli,
    input logic [DCNT_W-1:0]      dcnt
  );
    logic [16:0] frac;
    if (dcnt == DCNT_W'(1)) begin
      frac = 17'(milli) * 17'd100;
    end else if (dcnt == DCNT_W'(2)) begin
      frac = 17'(milli) * 17'd10;
    end else begin
      frac = 17'(milli);
    end
    return STAMP_W'(hour) * STAMP_W'(3600000) + STAMP_W'(minute) * STAMP_W'(60000) +
           STAMP_W'(second) * STAMP_W'(1000) + STAMP_W'(frac);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/srt_line_classifier.sv -----
// ----------------------------------------------------------------------------
// srt_line_classifier
// Throughput: one byte per cycle unless out_ready stalls the pipeline;
// the parser state updates on each transfer, then a capture stage and the
// output register (stamp multiply) follow.
// Reset: sync active-low rst_n clears phase, digit count, flags, both valids.
// Classifies one subtitle line: timecode stamps, blank and digits-only flags.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_line_classifier #(
  parameter int MAX_HOUR_DIGITS = slc_pkg::MAX_HOUR_DIGITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_ch,
  input  wire logic                        in_has_char,
  input  wire logic                        in_line_end,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_is_timecode,
  output logic [slc_pkg::STAMP_W-1:0]      out_start_ms,
  output logic [slc_pkg::STAMP_W-1:0]      out_end_ms,
  output logic                             out_is_blank,
  output logic                             out_is_digits_only
);
  import slc_pkg::*;

  localparam int HourW = $clog2(10 ** MAX_HOUR_DIGITS);

  // parser state
  phase_t                  phase_r, phase_nxt;
  logic [DCNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic [HourW-1:0]        hour_r, hour_nxt;
  logic [MIN_ACC_W-1:0]    min_r, min_nxt;
  logic [SEC_ACC_W-1:0]    sec_r, sec_nxt;
  logic [MILLI_ACC_W-1:0]  milli_r, milli_nxt;
  logic [STAMP_W-1:0]      first_r, first_nxt;
  logic                    failed_r, failed_nxt;
  logic                    seen_r, seen_nxt;
  logic                    digs_r, digs_nxt;
  logic                    trail_r, trail_nxt;

  // capture stage
  logic                    f_vld_r;
  logic                    f_tc_r;
  logic [HourW-1:0]        f_hour_r;
  logic [MIN_ACC_W-1:0]    f_min_r;
  logic [SEC_ACC_W-1:0]    f_sec_r;
  logic [MILLI_ACC_W-1:0]  f_milli_r;
  logic [DCNT_W-1:0]       f_dcnt_r;
  logic [STAMP_W-1:0]      f_first_r;
  logic                    f_blank_r;
  logic                    f_digs_r;

  logic                    o_ready, f_ready, acc;
  logic                    is_dig, is_ws;
  logic [3:0]              dval;
  logic [7:0]              ch_off;
  logic                    tc_nxt;

  assign o_ready  = !out_valid || out_ready;
  assign f_ready  = !f_vld_r || o_ready;
  assign in_ready = f_ready;
  assign acc      = in_valid && in_ready;

  assign is_dig = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign is_ws  = (in_ch == CH_SPACE) || (in_ch == CH_TAB);
  assign ch_off = in_ch - CH_ZERO;
  assign dval   = is_dig ? ch_off[3:0] : 4'd0;

  always_comb begin
    phase_nxt  = phase_r;
    dcnt_nxt   = dcnt_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    sec_nxt    = sec_r;
    milli_nxt  = milli_r;
    first_nxt  = first_r;
    failed_nxt = failed_r;
    seen_nxt   = seen_r;
    digs_nxt   = digs_r;
    trail_nxt  = trail_r;

    if (in_has_char && !failed_r && (phase_r != PH_DONE)) begin
      case (phase_r)
        PH_WS0, PH_WS2: begin
          if (is_dig) begin
            hour_nxt  = HourW'(dval);
            min_nxt   = '0;
            sec_nxt   = '0;
            milli_nxt = '0;
            dcnt_nxt  = DCNT_W'(1);
            phase_nxt = (phase_r == PH_WS0) ? PH_H1 : PH_H2;
          end else if (!is_ws) begin
            failed_nxt = 1'b1;
          end
        end
        PH_H1, PH_H2: begin
          if (is_dig && (dcnt_r < DCNT_W'(MAX_HOUR_DIGITS))) begin
            hour_nxt = HourW'(hour_r * HourW'(10) + HourW'(dval));
            dcnt_nxt = dcnt_r + DCNT_W'(1);
          end else if ((in_ch == CH_COLON) && (dcnt_r != '0)) begin
            dcnt_nxt  = '0;
            phase_nxt = (phase_r == PH_H1) ? PH_M1 : PH_M2;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_M1, PH_M2: begin
          if (is_dig && (dcnt_r < DCNT_W'(2))) begin
            min_nxt  = MIN_ACC_W'(min_r * MIN_ACC_W'(10) + MIN_ACC_W'(dval));
            dcnt_nxt = dcnt_r + DCNT_W'(1);
          end else if ((in_ch == CH_COLON) && (dcnt_r == DCNT_W'(2))) begin
            dcnt_nxt  = '0;
            phase_nxt = (phase_r == PH_M1) ? PH_S1 : PH_S2;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_S1, PH_S2: begin
          if (is_dig && (dcnt_r < DCNT_W'(2))) begin
            sec_nxt  = SEC_ACC_W'(sec_r * SEC_ACC_W'(10) + SEC_ACC_W'(dval));
            dcnt_nxt = dcnt_r + DCNT_W'(1);
          end else if (((in_ch == CH_COMMA) || (in_ch == CH_PERIOD)) &&
                       (dcnt_r == DCNT_W'(2))) begin
            dcnt_nxt  = '0;
            phase_nxt = (phase_r == PH_S1) ? PH_F1 : PH_F2;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_F1, PH_F2: begin
          if (is_dig && (dcnt_r < DCNT_W'(3))) begin
            milli_nxt = MILLI_ACC_W'(milli_r * MILLI_ACC_W'(10) + MILLI_ACC_W'(dval));
            dcnt_nxt  = dcnt_r + DCNT_W'(1);
          end else if (dcnt_r == '0) begin
            failed_nxt = 1'b1;
          end else if (phase_r == PH_F2) begin
            phase_nxt = PH_DONE;
          end else begin
            first_nxt = stamp_ms(HOUR_ACC_W'(hour_r), min_r, sec_r, milli_r, dcnt_r);
            if (is_ws) begin
              phase_nxt = PH_WS1;
            end else if (in_ch == CH_DASH) begin
              phase_nxt = PH_D1;
            end else begin
              phase_nxt  = PH_WS1;
              failed_nxt = 1'b1;
            end
          end
        end
        PH_WS1: begin
          if (in_ch == CH_DASH) begin
            phase_nxt = PH_D1;
          end else if (!is_ws) begin
            failed_nxt = 1'b1;
          end
        end
        PH_D1: begin
          if (in_ch == CH_DASH) begin
            phase_nxt = PH_D2;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        PH_D2: begin
          if (in_ch == CH_GT) begin
            phase_nxt = PH_WS2;
          end else begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end

    if (in_has_char) begin
      if (in_ch <= CH_SPACE) begin
        if (seen_r) begin
          trail_nxt = 1'b1;
        end
      end else begin
        if (trail_r || !is_dig) begin
          digs_nxt = 1'b0;
        end
        seen_nxt  = 1'b1;
        trail_nxt = 1'b0;
      end
    end

    tc_nxt = !failed_nxt &&
             ((phase_nxt == PH_DONE) || ((phase_nxt == PH_F2) && (dcnt_nxt != '0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WS0;
      dcnt_r   <= '0;
      failed_r <= 1'b0;
      seen_r   <= 1'b0;
      digs_r   <= 1'b1;
      trail_r  <= 1'b0;
    end else if (acc) begin
      if (in_line_end) begin
        phase_r  <= PH_WS0;
        dcnt_r   <= '0;
        failed_r <= 1'b0;
        seen_r   <= 1'b0;
        digs_r   <= 1'b1;
        trail_r  <= 1'b0;
      end else begin
        phase_r  <= phase_nxt;
        dcnt_r   <= dcnt_nxt;
        failed_r <= failed_nxt;
        seen_r   <= seen_nxt;
        digs_r   <= digs_nxt;
        trail_r  <= trail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      hour_r  <= hour_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      milli_r <= milli_nxt;
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (f_ready) begin
      f_vld_r <= acc && in_line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_line_end) begin
      f_tc_r    <= tc_nxt;
      f_hour_r  <= hour_nxt;
      f_min_r   <= min_nxt;
      f_sec_r   <= sec_nxt;
      f_milli_r <= milli_nxt;
      f_dcnt_r  <= dcnt_nxt;
      f_first_r <= first_nxt;
      f_blank_r <= !seen_nxt;
      f_digs_r  <= seen_nxt && digs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && f_vld_r) begin
      out_is_timecode    <= f_tc_r;
      out_start_ms       <= f_tc_r ? f_first_r : '0;
      out_end_ms         <= f_tc_r ? stamp_ms(HOUR_ACC_W'(f_hour_r), f_min_r, f_sec_r,
                                              f_milli_r, f_dcnt_r) : '0;
      out_is_blank       <= f_blank_r;
      out_is_digits_only <= f_digs_r;
    end
  end

  a_zero_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_timecode) |-> ((out_start_ms == '0) && (out_end_ms == '0)))
    else $error("stamps nonzero on a non-timecode result");

  a_blank_vs_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_digits_only) |-> !out_is_blank)
    else $error("digits-only line flagged blank");

  a_line_end_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_line_end) |=> f_vld_r)
    else $error("line-end transfer not captured");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && !(acc && in_line_end)) |=> failed_r)
    else $error("parse failure cleared before line end");

endmodule

`default_nettype wire
